// File: rtl/vpv_pkg.sv
package vpv_pkg;

  localparam int FracBits = 16;
  localparam int DivBits  = 32 + FracBits;
  localparam logic MODE_XFORM = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef logic signed [31:0] fx_t;

  // 1.0 in fixed point
  localparam fx_t FxOne = 32'sd1 <<< FracBits;

  typedef struct packed {
    logic valid;
    logic zero_w;
  } stage_ctl_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic fx_t sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: rtl/vpv_matvec.sv
// One 4x4 matrix times a four-element vector. Two stages:
// products registered, then floor, sum and saturation registered.
module vpv_matvec (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  vpv_pkg::fx_t        m [16],
  input  vpv_pkg::fx_t        v [4],
  output logic                out_valid,
  output vpv_pkg::fx_t        r [4]
);

  logic signed [63:0] prod [16];
  logic               prod_valid;

  // stage 1: sixteen products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      prod[i] <= 64'(m[i]) * 64'(v[i % 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  // stage 2: floor shift, row sums, saturation
  always_ff @(posedge clk) begin
    for (int rw = 0; rw < 4; rw++) begin
      logic signed [49:0] acc;
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        acc = acc + 50'(prod[rw * 4 + c] >>> vpv_pkg::FracBits);
      end
      r[rw] <= vpv_pkg::sat64(64'(acc));
    end
  end

endmodule

// File: rtl/vpv_divider.sv
// Pipelined restoring divider: one quotient bit per stage, magnitude form,
// sign applied at the end. Quotient = trunc(num / den).
module vpv_divider (
  input  logic                                  clk,
  input  logic [vpv_pkg::DivBits-1:0]           num_mag,
  input  logic [31:0]                           den_mag,
  input  logic                                  neg,
  output logic signed [vpv_pkg::DivBits:0]      quot
);

  localparam int N = vpv_pkg::DivBits;

  logic [N-1:0] q   [N+1];
  logic [32:0]  rem [N+1];
  logic [31:0]  den [N+1];
  logic         sg  [N+1];

  always_comb begin
    q[0]   = num_mag;
    rem[0] = '0;
    den[0] = den_mag;
    sg[0]  = neg;
  end

  // one quotient bit per stage, registered
  for (genvar s = 0; s < N; s++) begin : g_step
    logic [33:0] trial;
    logic [33:0] shifted;
    assign shifted = {rem[s], q[s][N-1]};
    assign trial   = shifted - {2'b00, den[s]};
    always_ff @(posedge clk) begin
      den[s+1] <= den[s];
      sg[s+1]  <= sg[s];
      if (!trial[33]) begin
        rem[s+1] <= trial[32:0];
        q[s+1]   <= {q[s][N-2:0], 1'b1};
      end else begin
        rem[s+1] <= shifted[32:0];
        q[s+1]   <= {q[s][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= sg[N] ? -$signed({1'b0, q[N]}) : $signed({1'b0, q[N]});
  end

endmodule

// File: rtl/vpv_backend.sv
// Divide by clip w, map to 0..1 and apply the viewport.
module vpv_backend (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  vpv_pkg::fx_t        clip [4],
  input  logic [15:0]         org_x,
  input  logic [15:0]         org_y,
  input  logic [15:0]         size_x,
  input  logic [15:0]         size_y,
  output logic                out_valid,
  output vpv_pkg::fx_t        wx,
  output vpv_pkg::fx_t        wy,
  output vpv_pkg::fx_t        wz,
  output logic                wzero
);

  localparam int N    = vpv_pkg::DivBits;
  localparam int Lat  = N + 1;

  logic [N-1:0] nmag [3];
  logic [31:0]  dmag;
  logic         nneg [3];
  logic signed [N:0] quot [3];

  // operand magnitudes
  always_comb begin
    dmag = clip[3][31] ? 32'(-clip[3]) : 32'(clip[3]);
    for (int i = 0; i < 3; i++) begin
      logic [31:0] cm;
      cm = clip[i][31] ? 32'(-clip[i]) : 32'(clip[i]);
      nmag[i] = {cm, {vpv_pkg::FracBits{1'b0}}};
      nneg[i] = clip[i][31] ^ clip[3][31];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vpv_divider u_div (
      .clk(clk), .num_mag(nmag[i]), .den_mag(dmag), .neg(nneg[i]), .quot(quot[i])
    );
  end

  // control pipe alongside the divider
  vpv_pkg::stage_ctl_t ctl [Lat+1];
  assign ctl[0] = '{valid: in_valid, zero_w: (clip[3] == '0)};
  for (genvar s = 0; s < Lat; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) ctl[s+1] <= '0;
      else ctl[s+1] <= ctl[s];
    end
  end

  // map stage
  vpv_pkg::fx_t       mx, my, mz;
  vpv_pkg::stage_ctl_t mctl;
  always_ff @(posedge clk) begin
    if (rst) mctl <= '0;
    else mctl <= ctl[Lat];
  end
  always_ff @(posedge clk) begin
    logic signed [32:0] t;
    t = 33'(vpv_pkg::sat64(64'(quot[0]))) + 33'(vpv_pkg::FxOne);
    mx <= 32'(t >>> 1);
    t = 33'(vpv_pkg::sat64(64'(quot[1]))) + 33'(vpv_pkg::FxOne);
    my <= 32'(t >>> 1);
    t = 33'(vpv_pkg::sat64(64'(quot[2]))) + 33'(vpv_pkg::FxOne);
    mz <= 32'(t >>> 1);
  end

  // viewport multiply stage
  logic signed [63:0] px, py;
  vpv_pkg::fx_t pz;
  vpv_pkg::stage_ctl_t pctl;
  always_ff @(posedge clk) begin
    if (rst) pctl <= '0;
    else pctl <= mctl;
    px <= 64'(mx) * $signed({48'd0, size_x});
    py <= 64'(my) * $signed({48'd0, size_y});
    pz <= mz;
  end

  // offset and output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= pctl.valid;
    wzero <= pctl.zero_w;
    if (pctl.zero_w) begin
      wx <= '0; wy <= '0; wz <= '0;
    end else begin
      wx <= vpv_pkg::sat64(px + (64'(org_x) << vpv_pkg::FracBits));
      wy <= vpv_pkg::sat64(py + (64'(org_y) << vpv_pkg::FracBits));
      wz <= pz;
    end
  end

endmodule

// File: rtl/vertex_project_to_viewport_unit.sv
// Vertex projection to window coordinates, s15.16 fixed point.
// Requests enter on start while busy is low; busy is tied low, so one
// request is accepted every clock. mode = 1 writes one matrix entry
// (0-15 modelview, 16-31 projection) and gives no result; mode = 0
// transforms obj_x/y/z with w = 1.
// Each transform gives one result on win_x/win_y/win_z/w_was_zero with
// done high for one cycle, after the input register, two stages per
// matrix product, 48 stages of the one-bit-per-stage divider plus its
// sign stage, then map, viewport multiply and output stages.
// Throughput: one vertex per clock. Matrix loads take effect for the
// next request on the following cycle.
// Viewport registers are written on cfg_valid/cfg_ready (always ready);
// index 0 origin x, 1 origin y, 2 width, 3 height.
// Reset clears the pipeline valid bits and sets the viewport to 0,0,640,480;
// matrix contents are undefined until loaded. The receiver cannot stall.
module vertex_project_to_viewport_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic         mode,
  input  logic [4:0]   entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] obj_x,
  input  logic signed [31:0] obj_y,
  input  logic signed [31:0] obj_z,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output logic         done,
  output logic signed [31:0] win_x,
  output logic signed [31:0] win_y,
  output logic signed [31:0] win_z,
  output logic         w_was_zero
);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [15:0] org_x, org_y, size_x, size_y;

  // viewport registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= 16'd0; org_y <= 16'd0; size_x <= 16'd640; size_y <= 16'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        vpv_pkg::REG_ORIGIN_X: org_x  <= cfg_data;
        vpv_pkg::REG_ORIGIN_Y: org_y  <= cfg_data;
        vpv_pkg::REG_WIDTH:    size_x <= cfg_data;
        vpv_pkg::REG_HEIGHT:   size_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // matrix store; each entry wired to a fixed multiplier
  vpv_pkg::fx_t mv [16];
  vpv_pkg::fx_t pj [16];
  logic load, xform;
  assign load  = start && (mode == vpv_pkg::MODE_LOAD);
  assign xform = start && (mode == vpv_pkg::MODE_XFORM);

  // projection writes pass through the pj_ld delay registers, so they line
  // up with the projection product stage and leave earlier vertices untouched
  logic [2:0]   pj_ld_v;
  logic [3:0]   pj_ld_idx [3];
  vpv_pkg::fx_t pj_ld_val [3];
  always_ff @(posedge clk) begin
    if (rst) pj_ld_v <= '0;
    else pj_ld_v <= {pj_ld_v[1:0], load && entry_index[4]};
    pj_ld_idx[0] <= entry_index[3:0];
    pj_ld_val[0] <= entry_value;
    for (int i = 1; i < 3; i++) begin
      pj_ld_idx[i] <= pj_ld_idx[i-1];
      pj_ld_val[i] <= pj_ld_val[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (load && !entry_index[4]) mv[entry_index[3:0]] <= entry_value;
    if (pj_ld_v[2]) pj[pj_ld_idx[2]] <= pj_ld_val[2];
  end

  // input register
  vpv_pkg::fx_t obj [4];
  logic in_v;
  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else in_v <= xform;
    obj[0] <= obj_x;
    obj[1] <= obj_y;
    obj[2] <= obj_z;
    obj[3] <= vpv_pkg::FxOne;
  end

  vpv_pkg::fx_t eye [4];
  vpv_pkg::fx_t eye_w [4];
  vpv_pkg::fx_t clip [4];
  logic eye_v, clip_v;

  vpv_matvec u_mv (
    .clk(clk), .rst(rst), .in_valid(in_v), .m(mv), .v(obj),
    .out_valid(eye_v), .r(eye)
  );

  vpv_matvec u_pj (
    .clk(clk), .rst(rst), .in_valid(eye_v), .m(pj), .v(eye_w),
    .out_valid(clip_v), .r(clip)
  );
  assign eye_w = eye;

  vpv_backend u_be (
    .clk(clk), .rst(rst), .in_valid(clip_v), .clip(clip),
    .org_x(org_x), .org_y(org_y), .size_x(size_x), .size_y(size_y),
    .out_valid(done), .wx(win_x), .wy(win_y), .wz(win_z), .wzero(w_was_zero)
  );

  // a zero-w result carries zero coordinates
  a_zero_coords: assert property (@(posedge clk) disable iff (rst)
    done && w_was_zero |-> win_x == 0 && win_y == 0 && win_z == 0)
    else $error("zero w result with nonzero coordinates");

  // a load request never raises the input register's valid bit
  a_load_no_item: assert property (@(posedge clk) disable iff (rst)
    start && mode == vpv_pkg::MODE_LOAD |=> !in_v)
    else $error("load request entered the transform pipe");

endmodule
